### sv/fca_pkg.sv
`default_nettype none
package fca_pkg;

  localparam int unsigned KIND_W = 3;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned BID_W  = 10;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned BIU_W  = 11;
  localparam int unsigned TBL_W  = 7;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BLOCKS  = 1'b1;

  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;
  localparam logic [TBL_W-1:0] TBL_RESET = 7'd13;
  localparam int unsigned      TBL_OFFSET = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_FORMAT = 3'd0,
    KIND_CREATE = 3'd1,
    KIND_APPEND = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_NEXT   = 3'd4,
    KIND_FIRST  = 3'd5,
    KIND_REMOVE = 3'd6
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_EXISTS      = 3'd2,
    ST_DIR_FULL    = 3'd3,
    ST_DISK_FULL   = 3'd4,
    ST_NOT_IN_FILE = 3'd5,
    ST_EMPTY       = 3'd6
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FMT,
    OP_SCAN,
    OP_CREATE,
    OP_SETFIRST,
    OP_RD_HEAD,
    OP_RD_CUR,
    OP_POP,
    OP_SETF_ALLOC,
    OP_LINK_TAIL,
    OP_CUR_FIRST,
    OP_STEP,
    OP_NEXTLINK,
    OP_UNLINK,
    OP_FREE_CUR,
    OP_RM_STEP,
    OP_RM_END,
    OP_RES
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic hit;
    logic scan_done;
    logic free_found;
    logic head_zero;
    logic first_zero;
    logic cur_zero;
    logic cur_is_bid;
    logic n_max;
    logic link_zero;
    logic fmt_last;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/fca_ram.sv
`default_nettype none
module fca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]       wdata_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output logic      [WIDTH-1:0]       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### sv/fca_dp.sv
`default_nettype none
module fca_dp import fca_pkg::*; #(
  parameter int unsigned BLOCKS    = 1024,
  parameter int unsigned DIR_SLOTS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [KEY_W-1:0]     name_key_i,
  input  wire logic [BID_W-1:0]     block_id_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  output logic [STAT_W-1:0]         status_o,
  output logic [BID_W-1:0]          block_out_o
);
  localparam int unsigned AW   = $clog2(BLOCKS);
  localparam int unsigned CNTW = $clog2(BLOCKS + 1);
  localparam int unsigned NW   = (CNTW > BIU_W) ? CNTW : BIU_W;
  localparam int unsigned CW   = (AW > BID_W) ? AW : BID_W;
  localparam int unsigned SW   = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
  localparam int unsigned SCW  = $clog2(DIR_SLOTS + 1);

  logic [BIU_W-1:0]   biu_q;
  logic [TBL_W-1:0]   tb_q;
  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [BID_W-1:0]   bid_q;
  logic [AW-1:0]      head_q, cur_q, prev_q, alloc_q, res_q, first_q;
  logic [CNTW-1:0]    n_q;
  logic [SCW-1:0]     scan_q;
  logic [SW-1:0]      slot_q, free_q;
  logic               free_found_q;
  logic [DIR_SLOTS-1:0] used_q;
  logic [STAT_W-1:0]  status_q;
  logic [BID_W-1:0]   bout_q;

  logic [AW:0]        tab_rd, tab_wdata, fmt_val;
  logic [AW-1:0]      tab_raddr, tab_waddr, link_rd, fmt_head, first_rd, first_wdata;
  logic               tab_we, first_we, name_we;
  logic [SW-1:0]      first_waddr, pidx, sidx;
  logic [KEY_W-1:0]   name_rd;
  logic [NW-1:0]      n_ext, nb_eff, fst;
  logic               in_rng, is_last, hit, scan_open;

  // reserved entries carry the top bit and read as end of chain
  assign link_rd = tab_rd[AW] ? '0 : tab_rd[AW-1:0];

  assign n_ext   = NW'(n_q);
  assign nb_eff  = (NW'(biu_q) > NW'(BLOCKS)) ? NW'(BLOCKS) : NW'(biu_q);
  assign fst     = NW'(tb_q) + NW'(TBL_OFFSET);
  assign in_rng  = (n_ext >= fst) && (n_ext < nb_eff);
  assign is_last = NW'(n_ext + NW'(1)) == nb_eff;
  assign fmt_val = in_rng ? (is_last ? '0 : {1'b0, AW'(n_q + 1'b1)}) : {1'b1, {AW{1'b0}}};
  assign fmt_head = (fst < nb_eff) ? AW'(fst) : '0;

  assign pidx      = SW'(scan_q - 1'b1);
  assign sidx      = SW'(scan_q);
  assign scan_open = scan_q < SCW'(DIR_SLOTS);
  assign hit       = (scan_q != '0) && used_q[pidx] && (name_rd == key_q);

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = cur_q;
    tab_wdata = {1'b0, head_q};
    tab_raddr = (cmd_i.op == OP_RD_HEAD) ? head_q : cur_q;
    first_we    = 1'b0;
    first_waddr = slot_q;
    first_wdata = link_rd;
    name_we     = 1'b0;
    case (cmd_i.op)
      OP_FMT: begin
        tab_we    = 1'b1;
        tab_waddr = n_q[AW-1:0];
        tab_wdata = fmt_val;
      end
      OP_POP: begin
        tab_we    = 1'b1;
        tab_waddr = head_q;
        tab_wdata = '0;
      end
      OP_LINK_TAIL: begin
        tab_we    = 1'b1;
        tab_wdata = {1'b0, alloc_q};
      end
      OP_UNLINK: begin
        if (prev_q == '0) begin
          first_we = 1'b1;
        end else begin
          tab_we    = 1'b1;
          tab_waddr = prev_q;
          tab_wdata = {1'b0, link_rd};
        end
      end
      OP_FREE_CUR, OP_RM_STEP: begin
        tab_we = 1'b1;
      end
      OP_CREATE: begin
        name_we     = 1'b1;
        first_we    = 1'b1;
        first_waddr = free_q;
        first_wdata = '0;
      end
      OP_SETF_ALLOC: begin
        first_we    = 1'b1;
        first_wdata = alloc_q;
      end
      default: ;
    endcase
  end

  fca_ram #(.WIDTH(AW + 1), .DEPTH(BLOCKS)) u_table (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rd)
  );

  fca_ram #(.WIDTH(KEY_W), .DEPTH(DIR_SLOTS)) u_name (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (free_q),
    .wdata_i (key_q),
    .raddr_i (sidx),
    .rdata_o (name_rd)
  );

  fca_ram #(.WIDTH(AW), .DEPTH(DIR_SLOTS)) u_first (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (first_waddr),
    .wdata_i (first_wdata),
    .raddr_i (sidx),
    .rdata_o (first_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= BIU_RESET;
      tb_q  <= TBL_RESET;
      kind_q <= '0;
      key_q  <= '0;
      bid_q  <= '0;
      head_q <= '0;
      cur_q  <= '0;
      prev_q <= '0;
      alloc_q <= '0;
      res_q  <= '0;
      first_q <= '0;
      n_q    <= '0;
      scan_q <= '0;
      slot_q <= '0;
      free_q <= '0;
      free_found_q <= 1'b0;
      used_q <= '0;
      status_q <= '0;
      bout_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BLOCKS_IN_USE) begin
          biu_q <= cfg_data_i[BIU_W-1:0];
        end else begin
          tb_q <= cfg_data_i[TBL_W-1:0];
        end
      end
      case (cmd_i.op)
        OP_LOAD: begin
          kind_q <= kind_i;
          key_q  <= name_key_i;
          bid_q  <= block_id_i;
          scan_q <= '0;
          free_found_q <= 1'b0;
          res_q  <= '0;
          n_q    <= '0;
        end
        OP_FMT: begin
          n_q <= n_q + 1'b1;
          if (n_q == '0) begin
            head_q <= fmt_head;
            used_q <= '0;
          end
        end
        OP_SCAN: begin
          scan_q <= scan_q + 1'b1;
          if (hit) begin
            slot_q  <= pidx;
            first_q <= first_rd;
          end
          // remember the lowest unused slot for create
          if (scan_open && !used_q[sidx] && !free_found_q) begin
            free_q <= sidx;
            free_found_q <= 1'b1;
          end
        end
        OP_CREATE:   used_q[free_q] <= 1'b1;
        OP_SETFIRST: res_q <= first_q;
        OP_POP: begin
          alloc_q <= head_q;
          res_q   <= head_q;
          head_q  <= link_rd;
        end
        OP_CUR_FIRST: begin
          cur_q  <= first_q;
          prev_q <= '0;
          n_q    <= '0;
        end
        OP_STEP: begin
          prev_q <= cur_q;
          cur_q  <= link_rd;
          n_q    <= n_q + 1'b1;
        end
        OP_NEXTLINK: res_q <= link_rd;
        OP_FREE_CUR: head_q <= cur_q;
        OP_RM_STEP: begin
          head_q <= cur_q;
          cur_q  <= link_rd;
          n_q    <= n_q + 1'b1;
        end
        OP_RM_END: used_q[slot_q] <= 1'b0;
        OP_RES: begin
          status_q <= cmd_i.st;
          bout_q   <= (cmd_i.st == ST_OK) ? BID_W'(res_q) : '0;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.hit        = hit;
  assign stat_o.scan_done  = (scan_q == SCW'(DIR_SLOTS));
  assign stat_o.free_found = free_found_q;
  assign stat_o.head_zero  = (head_q == '0);
  assign stat_o.first_zero = (first_q == '0);
  assign stat_o.cur_zero   = (cur_q == '0);
  assign stat_o.cur_is_bid = (CW'(cur_q) == CW'(bid_q));
  assign stat_o.n_max      = (n_q == CNTW'(BLOCKS));
  assign stat_o.link_zero  = (link_rd == '0);
  assign stat_o.fmt_last   = (n_q == CNTW'(BLOCKS - 1));

  assign status_o    = status_q;
  assign block_out_o = bout_q;
endmodule
`default_nettype wire

### sv/fca_ctrl.sv
`default_nettype none
module fca_ctrl import fca_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_FMT, S_SCAN, S_FOUND, S_POP, S_APP, S_TAIL, S_TAIL_WAIT,
    S_WALK, S_WALK_WAIT, S_HIT_WAIT, S_FREE, S_RM, S_RM_WAIT, S_RES
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d  = state_q;
    st_d     = st_q;
    cmd_o.op = OP_NONE;
    cmd_o.st = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        st_d = ST_OK;
        case (stat_i.kind)
          KIND_FORMAT: state_d = S_FMT;
          KIND_CREATE, KIND_APPEND, KIND_DELETE, KIND_NEXT, KIND_FIRST,
          KIND_REMOVE: state_d = S_SCAN;
          default:     state_d = S_RES;
        endcase
      end
      S_FMT: begin
        cmd_o.op = OP_FMT;
        if (stat_i.fmt_last) state_d = S_RES;
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.hit) begin
          if (stat_i.kind == KIND_CREATE) begin
            st_d    = ST_EXISTS;
            state_d = S_RES;
          end else begin
            state_d = S_FOUND;
          end
        end else if (stat_i.scan_done) begin
          state_d = S_RES;
          if (stat_i.kind != KIND_CREATE) begin
            st_d = ST_NOT_FOUND;
          end else if (stat_i.free_found) begin
            state_d = S_FOUND;
          end else begin
            st_d = ST_DIR_FULL;
          end
        end
      end
      S_FOUND: begin
        state_d = S_RES;
        case (stat_i.kind)
          // a create arrives here only with no name match and a free slot
          KIND_CREATE: cmd_o.op = OP_CREATE;
          KIND_APPEND: begin
            if (stat_i.head_zero) begin
              st_d = ST_DISK_FULL;
            end else begin
              cmd_o.op = OP_RD_HEAD;
              state_d  = S_POP;
            end
          end
          KIND_DELETE, KIND_NEXT: begin
            cmd_o.op = OP_CUR_FIRST;
            state_d  = S_WALK;
          end
          KIND_FIRST: cmd_o.op = OP_SETFIRST;
          KIND_REMOVE: begin
            if (stat_i.first_zero) begin
              st_d = ST_EMPTY;
            end else begin
              cmd_o.op = OP_CUR_FIRST;
              state_d  = S_RM;
            end
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_APP;
      end
      S_APP: begin
        if (stat_i.first_zero) begin
          cmd_o.op = OP_SETF_ALLOC;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_CUR_FIRST;
          state_d  = S_TAIL;
        end
      end
      S_TAIL: begin
        if (stat_i.n_max) begin
          cmd_o.op = OP_LINK_TAIL;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_TAIL_WAIT;
        end
      end
      S_TAIL_WAIT: begin
        if (stat_i.link_zero) begin
          cmd_o.op = OP_LINK_TAIL;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_STEP;
          state_d  = S_TAIL;
        end
      end
      S_WALK: begin
        if (stat_i.n_max || stat_i.cur_zero) begin
          st_d    = ST_NOT_IN_FILE;
          state_d = S_RES;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = stat_i.cur_is_bid ? S_HIT_WAIT : S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd_o.op = OP_STEP;
        state_d  = S_WALK;
      end
      S_HIT_WAIT: begin
        if (stat_i.kind == KIND_NEXT) begin
          cmd_o.op = OP_NEXTLINK;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_UNLINK;
          state_d  = S_FREE;
        end
      end
      S_FREE: begin
        cmd_o.op = OP_FREE_CUR;
        state_d  = S_RES;
      end
      S_RM: begin
        if (stat_i.n_max || stat_i.cur_zero) begin
          cmd_o.op = OP_RM_END;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_RD_CUR;
          state_d  = S_RM_WAIT;
        end
      end
      S_RM_WAIT: begin
        cmd_o.op = OP_RM_STEP;
        state_d  = S_RM;
      end
      S_RES: begin
        // hold until the output register is free
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.op    = OP_RES;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule
`default_nettype wire

### sv/fat_chain_allocator.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------
// in       | in_valid_i / in_stall_o | kind_i, name_key_i, block_id_i
// out      | out_valid_o / out_stall_i | status_o, block_out_o
// cfg      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One command at a time. A command passes through accept and decode, a directory scan,
// a dispatch, chain steps (one table read each) with setup or closing steps, and a result;
// format writes one table entry per cycle.
// Reset clears the directory and empties the free list; the table is built by format.
// A stalled result holds in the output register; the next command is still taken.
`default_nettype none
module fat_chain_allocator import fca_pkg::*; #(
  parameter int unsigned BLOCKS    = 1024,
  parameter int unsigned DIR_SLOTS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [KIND_W-1:0]    kind_i,
  input  wire logic [KEY_W-1:0]     name_key_i,
  input  wire logic [BID_W-1:0]     block_id_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [STAT_W-1:0]         status_o,
  output logic [BID_W-1:0]          block_out_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fca_dp #(.BLOCKS(BLOCKS), .DIR_SLOTS(DIR_SLOTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .name_key_i  (name_key_i),
    .block_id_i  (block_id_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .status_o    (status_o),
    .block_out_o (block_out_o)
  );
endmodule
`default_nettype wire

### sv/fca_checker.sv
`default_nettype none
module fca_checker import fca_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [STAT_W-1:0] status_o,
  input wire logic [BID_W-1:0]  block_out_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(block_out_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> block_out_o == '0)
    else $error("error result carries a block");

  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while busy");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared the cycle after a transfer");
endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .block_out_o (block_out_o)
);
`default_nettype wire

### test/tb.sv
`default_nettype none
module tb;
  import fca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBLK = 1024;
  localparam int unsigned NSLOT = 32;
  localparam int unsigned RESERVED = 32'hFFFF_FFFF;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [KEY_W-1:0] name_key = '0;
  logic [BID_W-1:0] block_id = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [BID_W-1:0] block_out;

  fat_chain_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .name_key_i(name_key), .block_id_i(block_id),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .block_out_o(block_out)
  );

  typedef struct packed {
    logic [STAT_W-1:0] st;
    logic [BID_W-1:0]  blk;
  } fat_reply_t;

  // shadow of the allocation table and directory
  int unsigned fat_link [NBLK];
  logic [KEY_W-1:0] dir_key [NSLOT];
  bit dir_used [NSLOT];
  int unsigned dir_first [NSLOT];
  int unsigned blocks_reg;
  int unsigned table_reg;

  fat_reply_t pending_replies [$];
  int unsigned errors = 0;
  bit calm = 1'b0;
  logic [KEY_W-1:0] key_pool [40];
  int unsigned pool_size = 8;

  initial forever #4 clk = ~clk;

  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fat_chain_allocator: mismatch");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= !calm && ($urandom_range(0, 99) < 33);

  function automatic int unsigned link_at(int unsigned i);
    if (i >= NBLK || fat_link[i] >= NBLK) return 0;
    return fat_link[i];
  endfunction

  function automatic int find_file(logic [KEY_W-1:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (dir_used[i] && dir_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void release_block(int unsigned b);
    fat_link[b] = link_at(0);
    fat_link[0] = b;
  endfunction

  // position of b in the file's chain; prev is 0 when b heads the chain
  function automatic bit chain_holds(int s, int unsigned b, output int unsigned prev);
    int unsigned cur;
    cur = dir_first[s] < NBLK ? dir_first[s] : 0;
    prev = 0;
    for (int n = 0; n < NBLK && cur != 0; n++) begin
      if (cur == b) return 1'b1;
      prev = cur;
      cur = link_at(cur);
    end
    return 1'b0;
  endfunction

  function automatic void rebuild_table();
    int unsigned n, first;
    n = blocks_reg > NBLK ? NBLK : blocks_reg;
    first = table_reg + 2;
    for (int i = 0; i < NBLK; i++) fat_link[i] = RESERVED;
    if (first < n) begin
      fat_link[0] = first;
      for (int unsigned i = first; i + 1 < n; i++) fat_link[i] = i + 1;
      fat_link[n-1] = 0;
    end else begin
      fat_link[0] = 0;
    end
    for (int i = 0; i < NSLOT; i++) dir_used[i] = 1'b0;
  endfunction

  function automatic fat_reply_t run_command(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                                             int unsigned bid);
    fat_reply_t r;
    int s;
    int unsigned prev, head, cur;
    r.st = ST_OK;
    r.blk = '0;
    if (k == KIND_FORMAT) begin
      rebuild_table();
      return r;
    end
    if (k > KIND_REMOVE) return r;
    s = find_file(key);
    if (k == KIND_CREATE) begin
      if (s >= 0) r.st = ST_EXISTS;
      else begin
        r.st = ST_DIR_FULL;
        for (int i = 0; i < NSLOT; i++)
          if (!dir_used[i]) begin
            dir_used[i] = 1'b1;
            dir_key[i] = key;
            dir_first[i] = 0;
            r.st = ST_OK;
            break;
          end
      end
    end else if (s < 0) begin
      r.st = ST_NOT_FOUND;
    end else begin
      case (k)
        KIND_APPEND: begin
          head = link_at(0);
          if (head == 0) r.st = ST_DISK_FULL;
          else begin
            fat_link[0] = link_at(head);
            fat_link[head] = 0;
            cur = dir_first[s] < NBLK ? dir_first[s] : 0;
            if (cur == 0) dir_first[s] = head;
            else begin
              for (int n = 0; n < NBLK && link_at(cur) != 0; n++) cur = link_at(cur);
              fat_link[cur] = head;
            end
            r.blk = head;
          end
        end
        KIND_DELETE: begin
          if (!chain_holds(s, bid, prev)) r.st = ST_NOT_IN_FILE;
          else begin
            if (prev == 0) dir_first[s] = link_at(bid);
            else fat_link[prev] = link_at(bid);
            release_block(bid);
          end
        end
        KIND_NEXT: begin
          if (!chain_holds(s, bid, prev)) r.st = ST_NOT_IN_FILE;
          else r.blk = link_at(bid);
        end
        KIND_FIRST: r.blk = dir_first[s] < NBLK ? dir_first[s] : 0;
        default: begin
          cur = dir_first[s] < NBLK ? dir_first[s] : 0;
          if (cur == 0) r.st = ST_EMPTY;
          else begin
            for (int n = 0; n < NBLK && cur != 0; n++) begin
              dir_first[s] = link_at(cur);
              release_block(cur);
              cur = dir_first[s];
            end
            dir_first[s] = 0;
            dir_used[s] = 1'b0;
          end
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    fat_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) report_mismatch("unexpected result", status, -1);
      else begin
        want = pending_replies.pop_front();
        if (status !== want.st) report_mismatch("status", status, want.st);
        if (block_out !== want.blk) report_mismatch("block_out", block_out, want.blk);
      end
    end
  end

  // call right after a rising edge; leaves valid high for a following transfer
  task automatic send_command(logic [KIND_W-1:0] k, logic [KEY_W-1:0] key,
                              logic [BID_W-1:0] bid);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    name_key <= key;
    block_id <= bid;
    do @(posedge clk); while (in_stall);
    pending_replies = {pending_replies, run_command(k, key, bid)};
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCKS_IN_USE) blocks_reg = val & 32'h7FF;
    else table_reg = val & 32'h7F;
    @(posedge clk);
  endtask

  function automatic logic [BID_W-1:0] pick_block(logic [KEY_W-1:0] key);
    int unsigned found [$];
    int s;
    int unsigned cur;
    s = find_file(key);
    if (s >= 0 && $urandom_range(0, 99) < 80) begin
      cur = dir_first[s] < NBLK ? dir_first[s] : 0;
      for (int n = 0; n < NBLK && cur != 0; n++) begin
        found = {found, cur};
        cur = link_at(cur);
      end
    end
    if (found.size() == 0) return BID_W'($urandom_range(0, NBLK - 1));
    return BID_W'(found[$urandom_range(0, found.size() - 1)]);
  endfunction

  task automatic test_before_format();
    logic [KEY_W-1:0] a;
    a = 64'h0123_4567_89AB_CDEF;
    send_command(KIND_CREATE, a, 0);
    send_command(KIND_CREATE, a, 0);
    send_command(KIND_APPEND, a, 0);
    send_command(KIND_FIRST, a, 0);
    send_command(KIND_NEXT, a, 10'd5);
    send_command(KIND_DELETE, a, 10'd5);
    send_command(KIND_REMOVE, a, 0);
    send_command(KIND_FIRST, ~a, 0);
    send_command(3'd7, a, 10'h3FF);
    drain();
  endtask

  task automatic test_directed();
    logic [KEY_W-1:0] a, b;
    a = '0;
    b = '1;
    // smallest disk: one free block
    write_reg(CFG_BLOCKS_IN_USE, 4);
    write_reg(CFG_TABLE_BLOCKS, 1);
    send_command(KIND_FORMAT, 0, 0);
    send_command(KIND_CREATE, a, 0);
    send_command(KIND_CREATE, b, 0);
    send_command(KIND_APPEND, b, 0);
    send_command(KIND_APPEND, a, 0);
    send_command(KIND_NEXT, b, 10'd3);
    send_command(KIND_NEXT, b, 10'd0);
    send_command(KIND_DELETE, b, 10'h3FF);
    send_command(KIND_REMOVE, a, 0);
    send_command(KIND_DELETE, b, 10'd3);
    send_command(KIND_APPEND, a, 0);
    send_command(KIND_REMOVE, a, 0);
    send_command(KIND_FIRST, a, 0);
    drain();
    // table fills the disk: no free blocks
    write_reg(CFG_TABLE_BLOCKS, 2);
    send_command(KIND_FORMAT, 0, 0);
    send_command(KIND_CREATE, b, 0);
    send_command(KIND_APPEND, b, 0);
    drain();
    // oversized disk, largest table field
    write_reg(CFG_BLOCKS_IN_USE, 2047);
    write_reg(CFG_TABLE_BLOCKS, 127);
    send_command(KIND_FORMAT, 0, 0);
    send_command(KIND_CREATE, b, 0);
    send_command(KIND_APPEND, b, 0);
    send_command(KIND_NEXT, b, 10'd129);
    drain();
  endtask

  task automatic test_random(int sessions, int per_session);
    int unsigned r, biu, tb_cnt;
    logic [KEY_W-1:0] key;
    logic [KIND_W-1:0] k;
    for (int s = 0; s < sessions; s++) begin
      calm = (s == 3);
      r = $urandom_range(0, 99);
      biu = r < 70 ? $urandom_range(4, 80) : (r < 90 ? $urandom_range(81, 1024)
                                                     : $urandom_range(1025, 2047));
      tb_cnt = $urandom_range(0, 99) < 80 ? $urandom_range(1, 16) : $urandom_range(0, 127);
      write_reg(CFG_BLOCKS_IN_USE, biu);
      write_reg(CFG_TABLE_BLOCKS, tb_cnt);
      pool_size = (s % 3 == 0) ? 40 : $urandom_range(2, 10);
      for (int i = 0; i < pool_size; i++) key_pool[i] = {$urandom, $urandom};
      send_command(KIND_FORMAT, 0, 0);
      for (int i = 0; i < per_session; i++) begin
        key = key_pool[$urandom_range(0, pool_size - 1)];
        if ($urandom_range(0, 99) < 3) key = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 20) k = KIND_CREATE;
        else if (r < 50) k = KIND_APPEND;
        else if (r < 64) k = KIND_DELETE;
        else if (r < 79) k = KIND_NEXT;
        else if (r < 88) k = KIND_FIRST;
        else if (r < 96) k = KIND_REMOVE;
        else if (r < 98) k = KIND_FORMAT;
        else k = 3'd7;
        send_command(k, key, pick_block(key));
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NBLK; i++) fat_link[i] = 0;
    for (int i = 0; i < NSLOT; i++) begin
      dir_used[i] = 1'b0;
      dir_key[i] = '0;
      dir_first[i] = 0;
    end
    blocks_reg = BIU_RESET;
    table_reg = TBL_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_before_format();
    test_directed();
    test_random(12, 110);
    if (errors == 0) $display("fat_chain_allocator: match");
    else $display("fat_chain_allocator: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
sv/fca_pkg.sv
sv/fca_ram.sv
sv/fca_dp.sv
sv/fca_ctrl.sv
sv/fat_chain_allocator.sv
sv/fca_checker.sv
test/tb.sv
